[hdl/fpc_pkg.sv]
`timescale 1ns / 1ps

package fpc_pkg;

    // Default number of fraction bits in the controller's Q values
    localparam int FRAC_BITS_DEF = 16;
    // Fraction bits of the low-pass coefficients
    localparam int COEF_BITS = 20;

    // Working width for signed intermediate sums
    typedef logic signed [71:0] wide_t;
    typedef logic signed [21:0] coef_t;

    // Operations of the shared serial arithmetic unit
    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_sts_t;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_GAINP = 3'd1;
    localparam logic [2:0] REG_GAINI = 3'd2;
    localparam logic [2:0] REG_GAIND = 3'd3;
    localparam logic [2:0] REG_LIMIT = 3'd4;
    localparam logic [2:0] REG_FADE  = 3'd5;

    // Time step limits in microseconds
    localparam logic [15:0] DT_MIN = 16'd1000;
    localparam logic [15:0] DT_MAX = 16'd50000;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [18:0] HALF_SEC_US  = 19'd500000;

    localparam wide_t S32_MAX = 72'sd2147483647;
    localparam wide_t S32_MIN = -72'sd2147483648;

    // Biquad coefficients: b0, b1, a1, a2 (Q20); fast is 30 Hz, slow is 10 Hz
    function automatic coef_t lp_coef(logic slow, logic [1:0] k);
        coef_t c;
        c = '0;
        case ({slow, k})
            3'b000:  c = 22'sd410345;
            3'b001:  c = 22'sd820690;
            3'b010:  c = 22'sd387478;
            3'b011:  c = 22'sd205328;
            3'b100:  c = 22'sd70732;
            3'b101:  c = 22'sd141464;
            3'b110:  c = -22'sd1198502;
            default: c = 22'sd432854;
        endcase
        return c;
    endfunction

    // Round to nearest (ties up) while shifting right, modulo 2^64
    function automatic logic [63:0] urnd(logic [63:0] v, int unsigned s);
        return (v + ((64'd1 << s) >> 1)) >> s;
    endfunction

    // Signed rounding shift, ties away from zero
    function automatic wide_t srnd(wide_t v, int unsigned s);
        logic [71:0] m;
        m = v[71] ? 72'(-v) : 72'(v);
        m = (m + ((72'd1 << s) >> 1)) >> s;
        return v[71] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] mag64(wide_t v);
        logic [71:0] m;
        m = v[71] ? 72'(-v) : 72'(v);
        return m[63:0];
    endfunction

    function automatic wide_t sapply(logic [63:0] m, logic neg);
        wide_t w;
        w = $signed({8'd0, m});
        return neg ? -w : w;
    endfunction

    function automatic logic signed [31:0] sat32(wide_t v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic wide_t clampw(wide_t v, wide_t lo, wide_t hi);
        wide_t r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hdl/fpc_serial_arith.sv]
`timescale 1ns / 1ps

// Shared bit-serial unit: shift-add multiply (one multiplier bit a cycle,
// stops when the remaining multiplier bits are zero) and restoring divide
// (one quotient bit a cycle).
module fpc_serial_arith (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpc_pkg::arith_req_t   req,
    input  logic [63:0]           a,
    input  logic [63:0]           b,
    output fpc_pkg::arith_sts_t   sts,
    output logic [63:0]           res
);

    localparam int QBITS = 64;
    localparam int CW = $clog2(QBITS + 1);

    logic                busy_reg;
    logic                done_reg;
    fpc_pkg::arith_op_t  op_reg;
    logic [CW-1:0]       cnt_reg;
    logic [63:0]         acc_reg;
    logic [63:0]         a_sh_reg;
    logic [63:0]         b_sh_reg;

    logic                mul_end;
    logic                div_end;
    logic [32:0]         trial;
    logic [32:0]         diff;
    logic                ge;

    assign mul_end = (op_reg == fpc_pkg::OP_MUL) && (b_sh_reg == 64'd0);
    assign div_end = (op_reg == fpc_pkg::OP_DIV) && (cnt_reg == CW'(QBITS));

    // One divide step: shift in the next dividend bit, trial subtract
    assign trial = {acc_reg[31:0], a_sh_reg[63]};
    assign diff  = trial - {1'b0, b_sh_reg[31:0]};
    assign ge    = (trial >= {1'b0, b_sh_reg[31:0]});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= fpc_pkg::OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (mul_end || div_end)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= a;
            b_sh_reg <= b;
        end
        else if (busy_reg && !mul_end && !div_end)
        begin
            if (op_reg == fpc_pkg::OP_MUL)
            begin
                if (b_sh_reg[0])
                begin
                    acc_reg <= acc_reg + a_sh_reg;
                end
                a_sh_reg <= a_sh_reg << 1;
                b_sh_reg <= b_sh_reg >> 1;
            end
            else
            begin
                acc_reg  <= {32'd0, ge ? diff[31:0] : trial[31:0]};
                a_sh_reg <= {a_sh_reg[62:0], ge};
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res      = (op_reg == fpc_pkg::OP_DIV) ? a_sh_reg : acc_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("arith started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("arith done without a running operation");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && op_reg == fpc_pkg::OP_DIV) |-> (cnt_reg <= CW'(QBITS)))
        else $error("divide step count overrun");

endmodule

[hdl/force_pid_controller.sv]
`timescale 1ns / 1ps

// Each word runs a sequence of operations in the shared bit-serial unit, each one issued
// in S_ISSUE and awaited in S_WAIT; a product handles one bit of its second operand a
// cycle and stops after its highest set bit. The next word waits for the last result.
// Reset (rst_n, async, active low) clears mode, gain and limit registers, PID state and
// filter delays, and sets the fade register to 1.0.
module force_pid_controller #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // force_err[31:0], elapsed_us[63:32]
    input  logic        s_tuser,   // clear[0]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // drive[16:0], integral_term[48:17], zero pad
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = FRAC_BITS + 1;
    localparam int DSH_R = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int DSH_L = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
    localparam logic [AW-1:0] ONE_A = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [63:0] ONE_64 = 64'd1 << FRAC_BITS;
    localparam fpc_pkg::wide_t ONE_W = fpc_pkg::wide_t'(72'd1 << FRAC_BITS);
    localparam logic [30:0] FADE_RST = 31'(64'd1 << FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ISSUE  = 5'b00010,
        S_WAIT   = 5'b00100,
        S_FINISH = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    typedef enum logic [17:0] {
        ST_M0_P   = 18'h00001,
        ST_M0_I   = 18'h00002,
        ST_M0_D   = 18'h00004,
        ST_F_A    = 18'h00008,
        ST_F_B    = 18'h00010,
        ST_F_C    = 18'h00020,
        ST_F_D    = 18'h00040,
        ST_F_E    = 18'h00080,
        ST_M1_P   = 18'h00100,
        ST_M1_Q   = 18'h00200,
        ST_M1_QM  = 18'h00400,
        ST_M1_QD  = 18'h00800,
        ST_M1_R   = 18'h01000,
        ST_M1_RR  = 18'h02000,
        ST_M1_T   = 18'h04000,
        ST_M1_U1  = 18'h08000,
        ST_M1_U2  = 18'h10000,
        ST_M1_INC = 18'h20000
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    // Registers
    logic        mode_reg;
    logic [30:0] gp_reg, gi_reg, gd_reg, lim_reg, base_reg;

    // Controller state
    logic [AW-1:0]      inc_acc_reg;
    logic signed [31:0] e1_reg, e2_reg, pint_reg, ple_reg;
    logic               tu_reg;
    logic signed [31:0] dly_reg [8];
    logic [1:0]         sel_reg;   // bit 0: derivative filter, bit 1: positional

    // Per-word working registers
    logic signed [31:0] err_reg, p_reg, d_reg, i_reg, w_reg, pf_reg, df_reg;
    logic [15:0]        dt_reg;
    fpc_pkg::wide_t     facc_reg;
    logic [63:0]        tmp_reg;
    logic               qneg_reg;
    logic [AW-1:0]      fw_reg;
    logic [AW-1:0]      drive_reg;
    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;

    // Arithmetic unit
    fpc_pkg::arith_req_t arith_req;
    fpc_pkg::arith_sts_t arith_sts;
    fpc_pkg::arith_op_t  op_kind;
    logic [63:0]         op_a, op_b, arith_res;
    logic                op_neg;

    logic accept, cfg_wr, post;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign post     = (state_reg == S_WAIT) && arith_sts.done;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Register read back
    always_comb
    begin
        unique case (paddr[4:2])
            fpc_pkg::REG_MODE:  prdata = {31'd0, mode_reg};
            fpc_pkg::REG_GAINP: prdata = {1'b0, gp_reg};
            fpc_pkg::REG_GAINI: prdata = {1'b0, gi_reg};
            fpc_pkg::REG_GAIND: prdata = {1'b0, gd_reg};
            fpc_pkg::REG_LIMIT: prdata = {1'b0, lim_reg};
            fpc_pkg::REG_FADE:  prdata = {1'b0, base_reg};
            default:            prdata = '0;
        endcase
    end

    // Time step from the incoming word
    logic [31:0] el_in;
    logic [15:0] dt_calc;
    assign el_in = s_tdata[63:32];
    always_comb
    begin
        if (s_tuser || tu_reg)
        begin
            dt_calc = fpc_pkg::DT_MAX;
        end
        else if (el_in < 32'(fpc_pkg::DT_MIN))
        begin
            dt_calc = fpc_pkg::DT_MIN;
        end
        else if (el_in > 32'(fpc_pkg::DT_MAX))
        begin
            dt_calc = fpc_pkg::DT_MAX;
        end
        else
        begin
            dt_calc = el_in[15:0];
        end
    end

    // Error differences and filter operands
    fpc_pkg::wide_t err_w, x_p0, x_d0, x_q, x_filt, d1_w, d2_w, w_w;
    fpc_pkg::coef_t c0, c1, c2, c3;
    logic [63:0]    mag_e;

    assign err_w  = fpc_pkg::wide_t'(err_reg);
    assign x_p0   = err_w - fpc_pkg::wide_t'(e1_reg);
    assign x_d0   = err_w - (fpc_pkg::wide_t'(e1_reg) <<< 1) + fpc_pkg::wide_t'(e2_reg);
    assign x_q    = err_w - fpc_pkg::wide_t'(ple_reg);
    assign mag_e  = fpc_pkg::mag64(err_w);
    assign d1_w   = fpc_pkg::wide_t'(dly_reg[0]);
    assign d2_w   = fpc_pkg::wide_t'(dly_reg[1]);
    assign w_w    = fpc_pkg::wide_t'(w_reg);
    assign x_filt = fpc_pkg::wide_t'(sel_reg[0] ? d_reg : p_reg) <<< fpc_pkg::COEF_BITS;
    assign c0     = fpc_pkg::lp_coef(sel_reg[0], 2'd0);
    assign c1     = fpc_pkg::lp_coef(sel_reg[0], 2'd1);
    assign c2     = fpc_pkg::lp_coef(sel_reg[0], 2'd2);
    assign c3     = fpc_pkg::lp_coef(sel_reg[0], 2'd3);

    // Operand selection per step
    always_comb
    begin
        op_kind = fpc_pkg::OP_MUL;
        op_a    = '0;
        op_b    = '0;
        op_neg  = 1'b0;
        case (step_reg)
            ST_M0_P:
            begin
                op_a = {33'd0, gp_reg};  op_b = fpc_pkg::mag64(x_p0); op_neg = x_p0[71];
            end
            ST_M0_I:
            begin
                op_a = {33'd0, gi_reg};  op_b = mag_e; op_neg = err_reg[31];
            end
            ST_M0_D:
            begin
                op_a = {33'd0, gd_reg};  op_b = fpc_pkg::mag64(x_d0); op_neg = x_d0[71];
            end
            ST_F_A:
            begin
                op_a = fpc_pkg::mag64(d1_w);
                op_b = fpc_pkg::mag64(fpc_pkg::wide_t'(c2));
                op_neg = dly_reg[0][31] ^ c2[21];
            end
            ST_F_B:
            begin
                op_a = fpc_pkg::mag64(d2_w);
                op_b = fpc_pkg::mag64(fpc_pkg::wide_t'(c3));
                op_neg = dly_reg[1][31] ^ c3[21];
            end
            ST_F_C:
            begin
                op_a = fpc_pkg::mag64(w_w);
                op_b = fpc_pkg::mag64(fpc_pkg::wide_t'(c0));
                op_neg = w_reg[31] ^ c0[21];
            end
            ST_F_D:
            begin
                op_a = fpc_pkg::mag64(d1_w);
                op_b = fpc_pkg::mag64(fpc_pkg::wide_t'(c1));
                op_neg = dly_reg[0][31] ^ c1[21];
            end
            ST_F_E:
            begin
                op_a = fpc_pkg::mag64(d2_w);
                op_b = fpc_pkg::mag64(fpc_pkg::wide_t'(c0));
                op_neg = dly_reg[1][31] ^ c0[21];
            end
            ST_M1_P:
            begin
                op_a = {33'd0, gp_reg};  op_b = mag_e; op_neg = err_reg[31];
            end
            ST_M1_Q:
            begin
                op_a = {33'd0, gd_reg};  op_b = fpc_pkg::mag64(x_q); op_neg = x_q[71];
            end
            ST_M1_QM:
            begin
                op_a = tmp_reg;  op_b = 64'(fpc_pkg::USEC_PER_SEC);
            end
            ST_M1_QD:
            begin
                op_kind = fpc_pkg::OP_DIV;
                op_a = tmp_reg + 64'(dt_reg >> 1);
                op_b = 64'(dt_reg);
            end
            ST_M1_R:
            begin
                op_kind = fpc_pkg::OP_DIV;
                op_a = mag_e << FRAC_BITS;
                op_b = {33'd0, base_reg};
            end
            ST_M1_RR:
            begin
                op_a = tmp_reg;  op_b = tmp_reg;
            end
            ST_M1_T:
            begin
                op_a = {33'd0, gi_reg};  op_b = mag_e;
            end
            ST_M1_U1:
            begin
                op_a = tmp_reg;  op_b = 64'(dt_reg);
            end
            ST_M1_U2:
            begin
                op_kind = fpc_pkg::OP_DIV;
                op_a = tmp_reg + 64'(fpc_pkg::HALF_SEC_US);
                op_b = 64'(fpc_pkg::USEC_PER_SEC);
            end
            ST_M1_INC:
            begin
                op_a = tmp_reg;  op_b = 64'(fw_reg);  op_neg = err_reg[31];
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // Result post-processing
    logic [63:0]        res_r;
    fpc_pkg::wide_t     res_s, prod_s, lim_w, facc_b, y_sum, pi_new, fin_sum, fin_clamp;
    fpc_pkg::wide_t     i_clamp;
    logic signed [31:0] res_sat, w_new, y_out;
    logic               q_big;

    assign res_r   = fpc_pkg::urnd(arith_res, FRAC_BITS);
    assign res_s   = fpc_pkg::sapply(res_r, op_neg);
    assign res_sat = fpc_pkg::sat32(res_s);
    assign prod_s  = fpc_pkg::sapply(arith_res, op_neg);
    assign lim_w   = $signed({41'd0, lim_reg});
    assign i_clamp = fpc_pkg::clampw(res_s, -lim_w, lim_w);
    assign facc_b  = facc_reg - prod_s;
    assign w_new   = fpc_pkg::sat32(fpc_pkg::srnd(facc_b, fpc_pkg::COEF_BITS));
    assign y_sum   = facc_reg + prod_s;
    assign y_out   = fpc_pkg::sat32(fpc_pkg::srnd(y_sum, fpc_pkg::COEF_BITS));
    assign pi_new  = fpc_pkg::clampw(fpc_pkg::wide_t'(pint_reg) + res_s, -lim_w, lim_w);
    assign q_big   = |res_r[63:31];

    // Output combine
    assign fin_sum = fpc_pkg::wide_t'(pf_reg) + fpc_pkg::wide_t'(i_reg)
                   + fpc_pkg::wide_t'(df_reg)
                   + (mode_reg ? fpc_pkg::wide_t'(0)
                               : $signed({{(72-AW){1'b0}}, inc_acc_reg}));
    assign fin_clamp = fpc_pkg::clampw(fin_sum, fpc_pkg::wide_t'(0), ONE_W);

    // Drive rescaled to Q1.16
    logic [63:0] drv64, drv_sc;
    assign drv64  = 64'(drive_reg);
    assign drv_sc = (DSH_L > 0) ? (drv64 << DSH_L) : fpc_pkg::urnd(drv64, DSH_R);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        arith_req.start = 1'b0;
        arith_req.op    = op_kind;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_ISSUE;
                    step_next  = mode_reg ? ST_M1_P : ST_M0_P;
                end
            end
            S_ISSUE:
            begin
                arith_req.start = 1'b1;
                state_next      = S_WAIT;
            end
            S_WAIT:
            begin
                if (arith_sts.done)
                begin
                    state_next = S_ISSUE;
                    case (step_reg)
                        ST_M0_P:  step_next = ST_M0_I;
                        ST_M0_I:  step_next = ST_M0_D;
                        ST_M0_D:  step_next = ST_F_A;
                        ST_F_A:   step_next = ST_F_B;
                        ST_F_B:   step_next = ST_F_C;
                        ST_F_C:   step_next = ST_F_D;
                        ST_F_D:   step_next = ST_F_E;
                        ST_F_E:
                        begin
                            if (sel_reg[0])
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                step_next = ST_F_A;
                            end
                        end
                        ST_M1_P:  step_next = ST_M1_Q;
                        ST_M1_Q:
                        begin
                            if (!q_big)
                            begin
                                step_next = ST_M1_QM;
                            end
                            else if (base_reg != 31'd0)
                            begin
                                step_next = ST_M1_R;
                            end
                            else
                            begin
                                step_next = ST_M1_T;
                            end
                        end
                        ST_M1_QM: step_next = ST_M1_QD;
                        ST_M1_QD: step_next = (base_reg != 31'd0) ? ST_M1_R : ST_M1_T;
                        ST_M1_R:  step_next = (arith_res >= ONE_64) ? ST_M1_T : ST_M1_RR;
                        ST_M1_RR: step_next = ST_M1_T;
                        ST_M1_T:  step_next = ST_M1_U1;
                        ST_M1_U1: step_next = ST_M1_U2;
                        ST_M1_U2: step_next = ST_M1_INC;
                        ST_M1_INC: step_next = ST_F_A;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_FINISH:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, registers and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= ST_M0_P;
            mode_reg     <= 1'b0;
            gp_reg       <= '0;
            gi_reg       <= '0;
            gd_reg       <= '0;
            lim_reg      <= '0;
            base_reg     <= FADE_RST;
            inc_acc_reg  <= '0;
            e1_reg       <= '0;
            e2_reg       <= '0;
            pint_reg     <= '0;
            ple_reg      <= '0;
            tu_reg       <= 1'b1;
            sel_reg      <= 2'b00;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    fpc_pkg::REG_MODE:  mode_reg <= pwdata[0];
                    fpc_pkg::REG_GAINP: gp_reg   <= pwdata[30:0];
                    fpc_pkg::REG_GAINI: gi_reg   <= pwdata[30:0];
                    fpc_pkg::REG_GAIND: gd_reg   <= pwdata[30:0];
                    fpc_pkg::REG_LIMIT: lim_reg  <= pwdata[30:0];
                    fpc_pkg::REG_FADE:  base_reg <= pwdata[30:0];
                    default: ;
                endcase
            end

            // Clear on clear flag; positional words bring their filter pairs to the head
            if (accept)
            begin
                if (s_tuser)
                begin
                    inc_acc_reg <= '0;
                    e1_reg      <= '0;
                    e2_reg      <= '0;
                    pint_reg    <= '0;
                    ple_reg     <= '0;
                    tu_reg      <= 1'b1;
                end
                if (mode_reg)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        dly_reg[i] <= dly_reg[(i + 4) % 8];
                    end
                end
            end

            if (post)
            begin
                if (step_reg == ST_M0_D)
                begin
                    sel_reg <= 2'b00;
                end
                if (step_reg == ST_M1_INC)
                begin
                    sel_reg  <= 2'b10;
                    pint_reg <= pi_new[31:0];
                end
                // Filter done: store new pair at the tail, rotate ring by one pair
                if (step_reg == ST_F_E)
                begin
                    sel_reg[0] <= 1'b1;
                    for (int i = 0; i < 6; i++)
                    begin
                        dly_reg[i] <= dly_reg[i + 2];
                    end
                    dly_reg[6] <= w_reg;
                    dly_reg[7] <= dly_reg[0];
                end
            end

            if (state_reg == S_FINISH)
            begin
                if (!mode_reg)
                begin
                    inc_acc_reg <= fin_clamp[AW-1:0];
                    e2_reg      <= e1_reg;
                    e1_reg      <= err_reg;
                    for (int i = 0; i < 8; i++)
                    begin
                        dly_reg[i] <= dly_reg[(i + 4) % 8];
                    end
                end
                else
                begin
                    ple_reg <= err_reg;
                    tu_reg  <= 1'b0;
                end
            end

            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg <= s_tdata[31:0];
            dt_reg  <= dt_calc;
        end
        if (post)
        begin
            case (step_reg)
                ST_M0_P:  p_reg <= res_sat;
                ST_M0_I:  i_reg <= i_clamp[31:0];
                ST_M0_D:  d_reg <= res_sat;
                ST_F_A:   facc_reg <= x_filt - prod_s;
                ST_F_B:   w_reg <= w_new;
                ST_F_C:   facc_reg <= prod_s;
                ST_F_D:   facc_reg <= y_sum;
                ST_F_E:
                begin
                    if (sel_reg[0])
                    begin
                        df_reg <= y_out;
                    end
                    else
                    begin
                        pf_reg <= y_out;
                    end
                end
                ST_M1_P:  p_reg <= res_sat;
                ST_M1_Q:
                begin
                    qneg_reg <= op_neg;
                    tmp_reg  <= res_r;
                    fw_reg   <= '0;
                    if (q_big)
                    begin
                        d_reg <= op_neg ? 32'sh80000000 : 32'sh7fffffff;
                    end
                end
                ST_M1_QM: tmp_reg <= arith_res;
                ST_M1_QD: d_reg <= fpc_pkg::sat32(fpc_pkg::sapply(arith_res, qneg_reg));
                ST_M1_R:  tmp_reg <= arith_res;
                ST_M1_RR: fw_reg <= ONE_A - res_r[AW-1:0];
                ST_M1_T:  tmp_reg <= res_r;
                ST_M1_U1: tmp_reg <= arith_res;
                ST_M1_U2: tmp_reg <= arith_res;
                ST_M1_INC: i_reg <= pi_new[31:0];
                default: ;
            endcase
        end
        if (state_reg == S_FINISH)
        begin
            drive_reg <= fin_clamp[AW-1:0];
        end
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {7'd0, i_reg, drv_sc[16:0]};
        end
    end

    fpc_serial_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .a     (op_a),
        .b     (op_b),
        .sts   (arith_sts),
        .res   (arith_res)
    );

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        inc_acc_reg <= ONE_A)
        else $error("incremental accumulator above one");

    a_issue_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |-> !arith_sts.busy)
        else $error("operation issued while arith unit busy");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (drive_reg <= ONE_A))
        else $error("drive above one");

endmodule

[verif/force_pid_checker.sv]
`timescale 1ns / 1ps

module force_pid_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam int FB = 16;

    typedef struct packed {
        logic [16:0] drive;
        logic [31:0] iterm;
    } pid_out_t;

    // shadow registers
    logic        cfg_mode;
    logic [30:0] kp, ki, kd, ilim, fade;

    // shadow controller state
    longint inc_acc, pos_int;
    longint inc_e1, inc_e2, pos_e1;
    bit     dt_unknown;
    longint lp_state [8];

    pid_out_t drive_q [$];

    function automatic longint rnd_u(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint rnd_s(longint v, int s);
        return (v < 0) ? -rnd_u(-v, s) : rnd_u(v, s);
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // gain * x, product can exceed 64 bits so use unsigned 96-bit math
    function automatic longint gain_mult(logic [30:0] g, longint x);
        logic [95:0] m;
        logic [95:0] p;
        m = (x < 0) ? 96'(-x) : 96'(x);
        p = (96'(g) * m + (96'd1 << (FB - 1))) >> FB;
        return (x < 0) ? -longint'(p) : longint'(p);
    endfunction

    // biquad section; slow picks the 10 Hz coefficient set
    function automatic longint biquad(int b, bit slow, longint x);
        longint c0, c1, c2, c3, d1, d2, w;
        logic signed [95:0] acc, y;
        c0 = slow ? 70732 : 410345;
        c1 = slow ? 141464 : 820690;
        c2 = slow ? -1198502 : 387478;
        c3 = slow ? 432854 : 205328;
        d1 = lp_state[b];
        d2 = lp_state[b + 1];
        acc = 96'(x) * (96'sd1 <<< 20) - 96'(d1) * 96'(c2) - 96'(d2) * 96'(c3);
        w = sat_s32(rnd_s(longint'(acc), 20));
        y = 96'(w) * 96'(c0) + 96'(d1) * 96'(c1) + 96'(d2) * 96'(c0);
        lp_state[b + 1] = d1;
        lp_state[b] = w;
        return sat_s32(rnd_s(longint'(y), 20));
    endfunction

    function automatic void zero_loop();
        inc_acc = 0; inc_e1 = 0; inc_e2 = 0;
        pos_int = 0; pos_e1 = 0; dt_unknown = 1;
    endfunction

    function automatic pid_out_t predict_drive(logic [31:0] err_raw, logic [31:0] el,
                                               bit clr);
        pid_out_t r;
        longint e, lim, p, i, d, pf, df, dr, q, qm, dm, inc;
        longint unsigned dt, mag, w, rr, t, u;
        e = longint'($signed(err_raw));
        lim = longint'(ilim);
        if (clr) zero_loop();
        if (!cfg_mode) begin
            p = sat_s32(gain_mult(kp, e - inc_e1));
            i = clip(gain_mult(ki, e), -lim, lim);
            d = sat_s32(gain_mult(kd, e - 2 * inc_e1 + inc_e2));
            pf = biquad(0, 0, p);
            df = biquad(2, 1, d);
            inc_acc = clip(inc_acc + pf + i + df, 0, 65536);
            inc_e2 = inc_e1;
            inc_e1 = e;
            dr = inc_acc;
            r.iterm = 32'(i);
        end else begin
            dt = dt_unknown ? 50000 : ((el < 1000) ? 1000 : ((el > 50000) ? 50000 : el));
            mag = (e < 0) ? -e : e;
            p = sat_s32(gain_mult(kp, e));
            q = gain_mult(kd, e - pos_e1);
            qm = (q < 0) ? -q : q;
            dm = (qm >= 64'sd2147483648) ? 64'sd1 <<< 40 : (qm * 1000000 + dt / 2) / dt;
            d = sat_s32((q < 0) ? -dm : dm);
            w = 0;
            if (fade != 0) begin
                rr = (mag << FB) / fade;
                if (rr < 65536) w = 65536 - rnd_u(rr * rr, FB);
            end
            t = rnd_u(longint'(ki) * mag, FB);
            u = (t * dt + 500000) / 1000000;
            inc = rnd_u(u * w, FB);
            pos_int = clip(pos_int + ((e < 0) ? -inc : inc), -lim, lim);
            pf = biquad(4, 0, p);
            df = biquad(6, 1, d);
            dr = clip(pf + pos_int + df, 0, 65536);
            pos_e1 = e;
            dt_unknown = 0;
            r.iterm = 32'(pos_int);
        end
        r.drive = 17'(dr);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pid_out_t exp_w, got;
        int errs;
        errs = 0;
        if (!rst_n) begin
            cfg_mode <= 0; kp <= 0; ki <= 0; kd <= 0; ilim <= 0; fade <= 31'd65536;
            zero_loop();
            for (int k = 0; k < 8; k++) lp_state[k] = 0;
            drive_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    fpc_pkg::REG_MODE:  cfg_mode <= pwdata[0];
                    fpc_pkg::REG_GAINP: kp <= pwdata[30:0];
                    fpc_pkg::REG_GAINI: ki <= pwdata[30:0];
                    fpc_pkg::REG_GAIND: kd <= pwdata[30:0];
                    fpc_pkg::REG_LIMIT: ilim <= pwdata[30:0];
                    fpc_pkg::REG_FADE:  fade <= pwdata[30:0];
                    default: ;
                endcase
            end
            // input word accepted
            if (s_tvalid && s_tready)
                drive_q.push_back(predict_drive(s_tdata[31:0], s_tdata[63:32], s_tuser));
            // output word compare
            if (m_tvalid && m_tready) begin
                got.drive = m_tdata[16:0];
                got.iterm = m_tdata[48:17];
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual drive=%0d iterm=%0d",
                             $time, got.drive, $signed(got.iterm));
                    errs++;
                end else begin
                    exp_w = drive_q.pop_front();
                    if (got.drive !== exp_w.drive) begin
                        $display("%0t: drive expected %0d actual %0d", $time,
                                 exp_w.drive, got.drive);
                        errs++;
                    end
                    if (got.iterm !== exp_w.iterm) begin
                        $display("%0t: integral_term expected %0d actual %0d", $time,
                                 $signed(exp_w.iterm), $signed(got.iterm));
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= drive_q.size();
        end
    end

endmodule

[verif/tb_force_pid_controller.sv]
`timescale 1ns / 1ps

module tb_force_pid_controller;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // force_err[31:0], elapsed_us[63:32]
    logic        s_tuser = 0;    // clear[0]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;        // drive[16:0], integral_term[48:17]
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          send_idle, recv_stall;

    always #6 clk = ~clk;

    force_pid_controller DUT (.*);

    force_pid_checker u_chk (.*);

    // receiver stalls
    always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // valid stays up after the handshake until the next word or an idle gap
    task automatic send_word(logic [31:0] err, logic [31:0] el, bit clr);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {el, err};
        s_tuser <= clr;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_err();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 262144)) - 131072);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 32'h7fffffff : 0;
            1: return $urandom();
            default: return $urandom_range(0, 4 * 65536);
        endcase
    endfunction

    initial begin
        logic [31:0] dir_err [8];
        dir_err = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h00010000,
                    32'hffff0000, 32'h00008000, 32'hffffffff, 32'h00000001};
        send_idle = 0; recv_stall = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1;
        repeat (2) @(negedge clk);

        // directed: both modes, extremes, clear, time step bounds
        for (int m = 0; m < 2; m++) begin
            write_reg(fpc_pkg::REG_MODE, m);
            write_reg(fpc_pkg::REG_GAINP, 32'h00010000);
            write_reg(fpc_pkg::REG_GAINI, 32'h00008000);
            write_reg(fpc_pkg::REG_GAIND, 32'h00004000);
            write_reg(fpc_pkg::REG_LIMIT, 32'h00020000);
            write_reg(fpc_pkg::REG_FADE, m ? 32'h7fffffff : 32'h00010000);
            for (int k = 0; k < 8; k++)
                send_word(dir_err[k], k[0] ? 32'd0 : 32'hffffffff, k == 4);
            send_word(32'h00000100, 32'd999, 0);
            send_word(32'h00000200, 32'd50001, 1);
            send_word(32'h00000300, 32'd1000, 0);
            drain();
        end
        write_reg(fpc_pkg::REG_FADE, 32'd1);
        send_word(32'h00000001, 32'd20000, 0);
        send_word(32'hfffffffe, 32'd20000, 0);
        drain();

        // random phases with new settings each
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 55; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 55; end
                default: begin send_idle = 8; recv_stall = 8; end
            endcase
            write_reg(fpc_pkg::REG_MODE, $urandom_range(1));
            write_reg(fpc_pkg::REG_GAINP, rand_gain());
            write_reg(fpc_pkg::REG_GAINI, rand_gain());
            write_reg(fpc_pkg::REG_GAIND, rand_gain());
            write_reg(fpc_pkg::REG_LIMIT, $urandom_range(1) ? $urandom() : 32'h7fffffff);
            write_reg(fpc_pkg::REG_FADE, $urandom_range(3) == 0 ? $urandom() :
                      $urandom_range(1, 1 << 20));
            for (int n = 0; n < 80; n++)
                send_word(rand_err(), $urandom_range(1) ? $urandom() :
                          $urandom_range(0, 60000), $urandom_range(15) == 0);
            drain();
        end

        if (fail_count == 0)
            $display("force_pid_controller verification clean");
        else
            $display("force_pid_controller verification failed");
        $finish;
    end

    initial begin
        #50ms;
        $display("force_pid_controller verification failed");
        $finish;
    end

endmodule

[sim.f]
hdl/fpc_pkg.sv
hdl/fpc_serial_arith.sv
hdl/force_pid_controller.sv
verif/force_pid_checker.sv
verif/tb_force_pid_controller.sv
